>>> src/fwo_pkg.sv
// ----------------------------------------------------------------------------
// fwo_pkg
// shared types, constants and tables of the four wheel encoder odometry block
// ----------------------------------------------------------------------------
package fwo_pkg;

  localparam int COUNT_BITS   = 32;
  localparam int CORDIC_STEPS = 16;

  localparam int DELTA_W   = COUNT_BITS + 3;
  localparam int MPC_W     = 24;
  localparam int A_W       = DELTA_W + MPC_W + 1;
  localparam int B_W       = 33;
  localparam int DIG_W     = 8;
  localparam int DIGITS    = (B_W + DIG_W - 1) / DIG_W;
  localparam int ACC_W     = A_W + B_W;
  localparam int RES_W     = 66;
  localparam int DEN_W     = 42;
  localparam int QUO_W     = 32;
  localparam int ANG_W     = 34;
  localparam int MOD_W     = 56;
  localparam int MOD_STEPS = 22;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 24;

  localparam logic [CFG_IDX_W-1:0] REG_MPC  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SIN  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COS  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ITR  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_LOW  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_CRIT = 3'd5;

  localparam logic [1:0] VS_NORMAL   = 2'd0;
  localparam logic [1:0] VS_LOW      = 2'd1;
  localparam logic [1:0] VS_CRITICAL = 2'd2;

  localparam logic [4:0] SH_NONE = 5'd0;
  localparam logic [4:0] SH_MIX  = 5'd24;
  localparam logic [4:0] SH_TURN = 5'd23;
  localparam logic [4:0] SH_ROT  = 5'd30;

  localparam logic signed [ANG_W-1:0] PI_Q29      = 34'sd1686629713;
  localparam logic signed [ANG_W-1:0] HALF_PI_Q29 = 34'sd843314857;
  localparam logic signed [ANG_W-1:0] GAIN_Q30    = 34'sd652032874;
  localparam logic [MOD_W-1:0]        TWO_PI_Q29  = 56'd3373259426;
  localparam logic [15:0]             RATE_SCALE  = 16'd15625;

  typedef struct packed {
    logic signed [31:0] front_left_count;
    logic signed [31:0] front_right_count;
    logic signed [31:0] back_right_count;
    logic signed [31:0] back_left_count;
    logic [31:0]        timestamp_us;
    logic [15:0]        supply_mv;
  } in_t;

  typedef struct packed {
    logic signed [47:0] x_position;
    logic signed [47:0] y_position;
    logic signed [31:0] heading;
    logic signed [31:0] velocity_x;
    logic signed [31:0] velocity_y;
    logic signed [31:0] yaw_rate;
    logic [1:0]         voltage_status;
  } out_t;

  typedef struct packed {
    logic [23:0]        metres_per_count;
    logic signed [15:0] mount_sine;
    logic signed [15:0] mount_cosine;
    logic [15:0]        inverse_turn_radius;
    logic [15:0]        low_voltage_mv;
    logic [15:0]        critical_voltage_mv;
  } cfg_t;

  typedef struct packed {
    logic signed [DELTA_W-1:0] cx;
    logic signed [DELTA_W-1:0] cy;
    logic signed [DELTA_W-1:0] cs;
    logic [31:0]               dt;
    logic [1:0]                status;
  } job_t;

  function automatic logic signed [ANG_W-1:0] atan_q29(input logic [4:0] idx);
    logic signed [ANG_W-1:0] v;
    case (idx)
      5'd0:  v = 34'sd421657428;
      5'd1:  v = 34'sd248918915;
      5'd2:  v = 34'sd131521918;
      5'd3:  v = 34'sd66762579;
      5'd4:  v = 34'sd33510843;
      5'd5:  v = 34'sd16771758;
      5'd6:  v = 34'sd8387925;
      5'd7:  v = 34'sd4194219;
      5'd8:  v = 34'sd2097141;
      5'd9:  v = 34'sd1048575;
      5'd10: v = 34'sd524288;
      5'd11: v = 34'sd262144;
      5'd12: v = 34'sd131072;
      5'd13: v = 34'sd65536;
      5'd14: v = 34'sd32768;
      5'd15: v = 34'sd16384;
      5'd16: v = 34'sd8192;
      5'd17: v = 34'sd4096;
      5'd18: v = 34'sd2048;
      5'd19: v = 34'sd1024;
      5'd20: v = 34'sd512;
      5'd21: v = 34'sd256;
      5'd22: v = 34'sd128;
      5'd23: v = 34'sd64;
      5'd24: v = 34'sd32;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

>>> src/four_wheel_encoder_odometry.sv
// ----------------------------------------------------------------------------
// four_wheel_encoder_odometry
// mecanum wheel dead reckoning from encoder counts, time and supply voltage
// ----------------------------------------------------------------------------
// The first item after reset only primes the stored counts and time and
// gives no result; every later item gives one pose, rate and voltage result.
// An item in the back end passes through the shared multiplier, which works
// at 8 bits of multiplier a cycle (thirteen products when elapsed time is
// nonzero, ten when it is zero), the 16 step cordic, the 22 step heading
// wrap and, only when elapsed time is nonzero, the bit serial divider for
// each of the three rates. A two entry queue lets the front accept items
// while the back end works.
module four_wheel_encoder_odometry import fwo_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  in_t                  in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output out_t                 out_data_o,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_DAT_W-1:0] cfg_wdata_i
);

  cfg_t cfg_q;
  logic q_full, q_valid, push, pop;
  job_t front_job, q_job;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.metres_per_count    <= 24'd1121600;
      cfg_q.mount_sine          <= 16'sd23170;
      cfg_q.mount_cosine        <= 16'sd23170;
      cfg_q.inverse_turn_radius <= 16'd5689;
      cfg_q.low_voltage_mv      <= 16'd10000;
      cfg_q.critical_voltage_mv <= 16'd9000;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_MPC:  cfg_q.metres_per_count    <= cfg_wdata_i;
        REG_SIN:  cfg_q.mount_sine          <= cfg_wdata_i[15:0];
        REG_COS:  cfg_q.mount_cosine        <= cfg_wdata_i[15:0];
        REG_ITR:  cfg_q.inverse_turn_radius <= cfg_wdata_i[15:0];
        REG_LOW:  cfg_q.low_voltage_mv      <= cfg_wdata_i[15:0];
        REG_CRIT: cfg_q.critical_voltage_mv <= cfg_wdata_i[15:0];
        default: ;
      endcase
    end
  end

  fwo_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .q_full_i   (q_full),
    .push_o     (push),
    .job_o      (front_job)
  );

  fwo_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (front_job),
    .full_o  (q_full),
    .pop_i   (pop),
    .valid_o (q_valid),
    .data_o  (q_job)
  );

  fwo_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .q_valid_i   (q_valid),
    .q_data_i    (q_job),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

>>> src/fwo_front.sv
// ----------------------------------------------------------------------------
// fwo_front
// takes telemetry items, forms count deltas, elapsed time and voltage grade
// ----------------------------------------------------------------------------
module fwo_front import fwo_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  cfg_t cfg_i,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  in_t  in_data_i,
  input  logic q_full_i,
  output logic push_o,
  output job_t job_o
);

  logic [COUNT_BITS-1:0] prev_q [4];
  logic [COUNT_BITS-1:0] cur    [4];
  logic [COUNT_BITS-1:0] diff   [4];
  logic signed [DELTA_W-1:0] d  [4];
  logic [31:0] prev_time_q;
  logic primed_q;
  logic accept;

  assign in_stall_o = q_full_i;
  assign accept     = in_valid_i && !q_full_i;
  assign push_o     = accept && primed_q;

  assign cur[0] = in_data_i.front_left_count[COUNT_BITS-1:0];
  assign cur[1] = in_data_i.front_right_count[COUNT_BITS-1:0];
  assign cur[2] = in_data_i.back_right_count[COUNT_BITS-1:0];
  assign cur[3] = in_data_i.back_left_count[COUNT_BITS-1:0];

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      diff[i] = cur[i] - prev_q[i];
      d[i]    = DELTA_W'($signed(diff[i]));
    end
  end

  always_comb begin
    job_o.cx = -d[0] - d[1] + d[2] + d[3];
    job_o.cy = -d[0] + d[1] + d[2] - d[3];
    job_o.cs = d[0] + d[1] + d[2] + d[3];
    job_o.dt = in_data_i.timestamp_us - prev_time_q;
    if (in_data_i.supply_mv < cfg_i.critical_voltage_mv) begin
      job_o.status = VS_CRITICAL;
    end else if (in_data_i.supply_mv < cfg_i.low_voltage_mv) begin
      job_o.status = VS_LOW;
    end else begin
      job_o.status = VS_NORMAL;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      primed_q    <= 1'b0;
      prev_time_q <= '0;
      for (int i = 0; i < 4; i++) prev_q[i] <= '0;
    end else if (accept) begin
      primed_q    <= 1'b1;
      prev_time_q <= in_data_i.timestamp_us;
      for (int i = 0; i < 4; i++) prev_q[i] <= cur[i];
    end
  end

endmodule

>>> src/fwo_fifo.sv
// ----------------------------------------------------------------------------
// fwo_fifo
// two entry queue between the front and the back
// ----------------------------------------------------------------------------
module fwo_fifo import fwo_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  job_t data_i,
  output logic full_o,
  input  logic pop_i,
  output logic valid_o,
  output job_t data_o
);

  job_t       mem_q [2];
  logic       wr_q;
  logic       rd_q;
  logic [1:0] cnt_q;

  assign full_o  = (cnt_q == 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign data_o  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= ~wr_q;
      if (pop_i) rd_q <= ~rd_q;
      cnt_q <= cnt_q + 2'(push_i) - 2'(pop_i);
    end
  end

endmodule

>>> src/fwo_mul.sv
// ----------------------------------------------------------------------------
// fwo_mul
// digit serial signed multiplier with rounding right shift
// ----------------------------------------------------------------------------
module fwo_mul import fwo_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  input  logic signed [A_W-1:0]   a_i,
  input  logic signed [B_W-1:0]   b_i,
  input  logic [4:0]              sh_i,
  output logic                    done_o,
  output logic signed [RES_W-1:0] res_o
);

  localparam int CNT_W = $clog2(DIGITS);

  logic [ACC_W-1:0]        aq_q;
  logic [DIGITS*DIG_W-1:0] bq_q;
  logic [ACC_W-1:0]        acc_q;
  logic [CNT_W-1:0]        cnt_q;
  logic [4:0]              sh_q;
  logic                    neg_q;
  logic                    busy_q;
  logic                    fin_q;
  logic                    done_q;
  logic signed [RES_W-1:0] res_q;
  logic [A_W-1:0]          a_mag;
  logic [B_W-1:0]          b_mag;
  logic [ACC_W-1:0]        half;
  logic [ACC_W-1:0]        rnd;
  logic [RES_W-1:0]        mag;

  assign a_mag = a_i[A_W-1] ? A_W'(-a_i) : A_W'(a_i);
  assign b_mag = b_i[B_W-1] ? B_W'(-b_i) : B_W'(b_i);

  always_comb begin
    half = (sh_q == SH_NONE) ? '0 : (ACC_W'(1) << (sh_q - 5'd1));
    rnd  = (acc_q + half) >> sh_q;
    mag  = rnd[RES_W-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      aq_q  <= ACC_W'(a_mag);
      bq_q  <= (DIGITS*DIG_W)'(b_mag);
      acc_q <= '0;
      sh_q  <= sh_i;
      neg_q <= a_i[A_W-1] ^ b_i[B_W-1];
    end else if (busy_q) begin
      acc_q <= acc_q + ACC_W'(aq_q * bq_q[DIG_W-1:0]);
      aq_q  <= aq_q << DIG_W;
      bq_q  <= bq_q >> DIG_W;
    end
    if (fin_q) res_q <= neg_q ? -$signed(mag) : $signed(mag);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      fin_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= fin_q;
      fin_q  <= !start_i && busy_q && (cnt_q == CNT_W'(DIGITS - 1));
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CNT_W'(DIGITS - 1)) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  assign done_o = done_q;
  assign res_o  = res_q;

endmodule

>>> src/fwo_div.sv
// ----------------------------------------------------------------------------
// fwo_div
// restoring divider, one quotient bit per cycle, flags quotients past 32 bits
// ----------------------------------------------------------------------------
module fwo_div import fwo_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [RES_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  output logic             done_o,
  output logic             sat_o,
  output logic [QUO_W-1:0] quo_o
);

  localparam int CNT_W = $clog2(QUO_W);

  logic [DEN_W-1:0] den_q;
  logic [DEN_W-1:0] rem_q;
  logic [QUO_W-1:0] bits_q;
  logic [QUO_W-1:0] quo_q;
  logic [CNT_W-1:0] cnt_q;
  logic             busy_q;
  logic             sat_q;
  logic             done_q;
  logic [DEN_W:0]   trial;
  logic             big;

  assign big   = (DEN_W+QUO_W)'(num_i) >= {den_i, {QUO_W{1'b0}}};
  assign trial = {rem_q, bits_q[QUO_W-1]};

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      den_q  <= den_i;
      rem_q  <= DEN_W'(num_i >> QUO_W);
      bits_q <= num_i[QUO_W-1:0];
      sat_q  <= big;
    end else if (busy_q) begin
      bits_q <= bits_q << 1;
      if (trial >= {1'b0, den_q}) begin
        rem_q <= DEN_W'(trial - {1'b0, den_q});
        quo_q <= {quo_q[QUO_W-2:0], 1'b1};
      end else begin
        rem_q <= trial[DEN_W-1:0];
        quo_q <= {quo_q[QUO_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      if (start_i) begin
        busy_q <= !big;
        done_q <= big;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q  <= cnt_q + 1'b1;
        done_q <= (cnt_q == CNT_W'(QUO_W - 1));
        if (cnt_q == CNT_W'(QUO_W - 1)) begin
          busy_q <= 1'b0;
        end
      end else begin
        done_q <= 1'b0;
      end
    end
  end

  assign done_o = done_q;
  assign sat_o  = sat_q;
  assign quo_o  = quo_q;

endmodule

>>> src/fwo_back.sv
// ----------------------------------------------------------------------------
// fwo_back
// sequencer: scaling, cordic rotation, pose update, heading wrap and rates
// ----------------------------------------------------------------------------
module fwo_back import fwo_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  cfg_t cfg_i,
  input  logic q_valid_i,
  input  job_t q_data_i,
  output logic pop_o,
  output logic out_valid_o,
  input  logic out_stall_i,
  output out_t out_data_o
);

  localparam logic [3:0] ST_IDLE     = 4'd0;
  localparam logic [3:0] ST_MUL_GO   = 4'd1;
  localparam logic [3:0] ST_MUL_WAIT = 4'd2;
  localparam logic [3:0] ST_CORDIC   = 4'd3;
  localparam logic [3:0] ST_MOD      = 4'd4;
  localparam logic [3:0] ST_DIV_GO   = 4'd5;
  localparam logic [3:0] ST_DIV_WAIT = 4'd6;
  localparam logic [3:0] ST_OUT      = 4'd7;

  localparam logic [3:0] J_X   = 4'd0;
  localparam logic [3:0] J_Y   = 4'd1;
  localparam logic [3:0] J_S   = 4'd2;
  localparam logic [3:0] J_HX  = 4'd3;
  localparam logic [3:0] J_HY  = 4'd4;
  localparam logic [3:0] J_DTH = 4'd5;
  localparam logic [3:0] J_P1  = 4'd6;
  localparam logic [3:0] J_P2  = 4'd7;
  localparam logic [3:0] J_P3  = 4'd8;
  localparam logic [3:0] J_P4  = 4'd9;
  localparam logic [3:0] J_VX  = 4'd10;
  localparam logic [3:0] J_VY  = 4'd11;
  localparam logic [3:0] J_W   = 4'd12;

  localparam int STEP_W = $clog2(CORDIC_STEPS);
  localparam int K_W    = $clog2(MOD_STEPS);

  localparam logic signed [RES_W-1:0] POS_MAX = RES_W'(48'sh7FFF_FFFF_FFFF);
  localparam logic signed [RES_W-1:0] POS_MIN = -POS_MAX - RES_W'(1);

  logic [3:0] state_q;
  logic [3:0] job_q;

  job_t                    job_q_data;
  logic signed [RES_W-1:0] x_q, y_q, s_q, hx_q, hy_q, dth_q, tmp_q;
  logic signed [ANG_W-1:0] cos_q, sin_q;
  logic signed [ANG_W-1:0] crd_x_q, crd_y_q, crd_z_q;
  logic                    flip_q;
  logic [STEP_W-1:0]       step_q;
  logic [MOD_W-1:0]        mod_q;
  logic                    mod_neg_q;
  logic [K_W-1:0]          k_q;
  logic signed [47:0]      gx_q, gy_q;
  logic signed [31:0]      head_q;
  logic [31:0]             vx_q, vy_q, w_q;
  logic                    out_valid_q;
  out_t                    out_q;

  logic                    mul_start, mul_done;
  logic signed [A_W-1:0]   mul_a;
  logic signed [B_W-1:0]   mul_b;
  logic [4:0]              mul_sh;
  logic signed [RES_W-1:0] mul_res;
  logic                    div_start, div_done, div_sat;
  logic [RES_W-1:0]        div_num;
  logic [DEN_W-1:0]        div_den;
  logic [QUO_W-1:0]        div_quo;

  logic signed [ANG_W-1:0] crd_ys, crd_xs, crd_atan, crd_z0;
  logic [MOD_W-1:0]        mod_cand, mod_next;
  logic signed [RES_W-1:0] head_sum;
  logic signed [ANG_W-1:0] head_t, head_fix;
  logic signed [RES_W-1:0] pos_sum;
  logic signed [RES_W-1:0] rate_src;
  logic [31:0]             rate_val;
  logic                    out_free;

  function automatic logic signed [47:0] sat48(input logic signed [RES_W-1:0] v);
    logic signed [47:0] r;
    if (v > POS_MAX) r = POS_MAX[47:0];
    else if (v < POS_MIN) r = POS_MIN[47:0];
    else r = v[47:0];
    return r;
  endfunction

  function automatic logic [31:0] rate_sat(input logic neg, input logic sat,
                                           input logic [31:0] t);
    logic [31:0] r;
    if (neg) begin
      if (sat || t > 32'h8000_0000) r = 32'h8000_0000;
      else r = -t;
    end else begin
      if (sat || t[31]) r = 32'h7FFF_FFFF;
      else r = t;
    end
    return r;
  endfunction

  assign mul_start = (state_q == ST_MUL_GO);
  assign div_start = (state_q == ST_DIV_GO);
  assign pop_o     = (state_q == ST_IDLE) && q_valid_i;
  assign out_free  = !out_valid_q || !out_stall_i;

  always_comb begin
    mul_a  = '0;
    mul_b  = '0;
    mul_sh = SH_NONE;
    case (job_q)
      J_X: begin
        mul_a = A_W'(job_q_data.cx);
        mul_b = B_W'($signed({1'b0, cfg_i.metres_per_count}));
      end
      J_Y: begin
        mul_a = A_W'(job_q_data.cy);
        mul_b = B_W'($signed({1'b0, cfg_i.metres_per_count}));
      end
      J_S: begin
        mul_a = A_W'(job_q_data.cs);
        mul_b = B_W'($signed({1'b0, cfg_i.metres_per_count}));
      end
      J_HX: begin
        mul_a  = A_W'(x_q);
        mul_b  = B_W'(cfg_i.mount_sine);
        mul_sh = SH_MIX;
      end
      J_HY: begin
        mul_a  = A_W'(y_q);
        mul_b  = B_W'(cfg_i.mount_cosine);
        mul_sh = SH_MIX;
      end
      J_DTH: begin
        mul_a  = A_W'(s_q);
        mul_b  = B_W'($signed({1'b0, cfg_i.inverse_turn_radius}));
        mul_sh = SH_TURN;
      end
      J_P1: begin
        mul_a  = A_W'(hx_q);
        mul_b  = B_W'(cos_q);
        mul_sh = SH_ROT;
      end
      J_P2: begin
        mul_a  = A_W'(hy_q);
        mul_b  = B_W'(sin_q);
        mul_sh = SH_ROT;
      end
      J_P3: begin
        mul_a  = A_W'(hx_q);
        mul_b  = B_W'(sin_q);
        mul_sh = SH_ROT;
      end
      J_P4: begin
        mul_a  = A_W'(hy_q);
        mul_b  = B_W'(cos_q);
        mul_sh = SH_ROT;
      end
      J_VX, J_VY, J_W: begin
        mul_a = rate_src[RES_W-1] ? A_W'(-rate_src) : A_W'(rate_src);
        mul_b = B_W'($signed({1'b0, RATE_SCALE}));
      end
      default: ;
    endcase
  end

  always_comb begin
    case (job_q)
      J_VX:    rate_src = hx_q;
      J_VY:    rate_src = hy_q;
      default: rate_src = dth_q;
    endcase
    if (job_q == J_W) begin
      div_num = RES_W'(tmp_q) + (RES_W'(job_q_data.dt) << 6);
      div_den = DEN_W'(job_q_data.dt) << 7;
    end else begin
      div_num = RES_W'(tmp_q) + (RES_W'(job_q_data.dt) << 9);
      div_den = DEN_W'(job_q_data.dt) << 10;
    end
    rate_val = rate_sat(rate_src[RES_W-1], div_sat, div_quo);
  end

  always_comb begin
    crd_xs   = crd_x_q >>> step_q;
    crd_ys   = crd_y_q >>> step_q;
    crd_atan = atan_q29(5'(step_q));
    crd_z0   = ANG_W'(head_q);
    mod_cand = TWO_PI_Q29 << k_q;
    mod_next = (mod_q >= mod_cand) ? mod_q - mod_cand : mod_q;
    head_t   = mod_neg_q ? -$signed(ANG_W'(mod_next)) : $signed(ANG_W'(mod_next));
    if (head_t > PI_Q29) head_fix = head_t - $signed(ANG_W'(TWO_PI_Q29));
    else if (head_t < -PI_Q29) head_fix = head_t + $signed(ANG_W'(TWO_PI_Q29));
    else head_fix = head_t;
    head_sum = RES_W'(head_q) + dth_q;
    if (job_q == J_P2) pos_sum = RES_W'(gx_q) + tmp_q - mul_res;
    else pos_sum = RES_W'(gy_q) + tmp_q + mul_res;
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (q_valid_i) job_q_data <= q_data_i;
      end
      ST_MUL_WAIT: begin
        if (mul_done) begin
          case (job_q)
            J_X:   x_q   <= mul_res;
            J_Y:   y_q   <= mul_res;
            J_S:   s_q   <= mul_res;
            J_HX:  hx_q  <= mul_res;
            J_HY:  hy_q  <= mul_res;
            J_DTH: begin
              dth_q   <= mul_res;
              crd_x_q <= GAIN_Q30;
              crd_y_q <= '0;
              if (crd_z0 > HALF_PI_Q29) begin
                crd_z_q <= crd_z0 - PI_Q29;
                flip_q  <= 1'b1;
              end else if (crd_z0 < -HALF_PI_Q29) begin
                crd_z_q <= crd_z0 + PI_Q29;
                flip_q  <= 1'b1;
              end else begin
                crd_z_q <= crd_z0;
                flip_q  <= 1'b0;
              end
            end
            J_P4: begin
              mod_neg_q <= head_sum[RES_W-1];
              mod_q     <= head_sum[RES_W-1] ? MOD_W'(-head_sum) : MOD_W'(head_sum);
            end
            default: tmp_q <= mul_res;
          endcase
        end
      end
      ST_CORDIC: begin
        if (crd_z_q >= 0) begin
          crd_x_q <= crd_x_q - crd_ys;
          crd_y_q <= crd_y_q + crd_xs;
          crd_z_q <= crd_z_q - crd_atan;
          cos_q   <= flip_q ? -(crd_x_q - crd_ys) : crd_x_q - crd_ys;
          sin_q   <= flip_q ? -(crd_y_q + crd_xs) : crd_y_q + crd_xs;
        end else begin
          crd_x_q <= crd_x_q + crd_ys;
          crd_y_q <= crd_y_q - crd_xs;
          crd_z_q <= crd_z_q + crd_atan;
          cos_q   <= flip_q ? -(crd_x_q + crd_ys) : crd_x_q + crd_ys;
          sin_q   <= flip_q ? -(crd_y_q - crd_xs) : crd_y_q - crd_xs;
        end
      end
      ST_MOD: begin
        mod_q <= mod_next;
      end
      default: ;
    endcase
    if (state_q == ST_DIV_WAIT && div_done) begin
      case (job_q)
        J_VX:    vx_q <= rate_val;
        J_VY:    vy_q <= rate_val;
        default: w_q  <= rate_val;
      endcase
    end
    if (state_q == ST_MOD && k_q == '0 && job_q_data.dt == '0) begin
      vx_q <= '0;
      vy_q <= '0;
      w_q  <= '0;
    end
    if (state_q == ST_OUT && out_free) begin
      out_q.x_position     <= gx_q;
      out_q.y_position     <= gy_q;
      out_q.heading        <= head_q;
      out_q.velocity_x     <= vx_q;
      out_q.velocity_y     <= vy_q;
      out_q.yaw_rate       <= w_q;
      out_q.voltage_status <= job_q_data.status;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      job_q       <= J_X;
      step_q      <= '0;
      k_q         <= '0;
      gx_q        <= '0;
      gy_q        <= '0;
      head_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (state_q == ST_OUT && out_free) out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
      case (state_q)
        ST_IDLE: begin
          if (q_valid_i) begin
            job_q   <= J_X;
            state_q <= ST_MUL_GO;
          end
        end
        ST_MUL_GO: state_q <= ST_MUL_WAIT;
        ST_MUL_WAIT: begin
          if (mul_done) begin
            case (job_q)
              J_DTH: begin
                step_q  <= '0;
                state_q <= ST_CORDIC;
              end
              J_P2: begin
                gx_q    <= sat48(pos_sum);
                job_q   <= job_q + 4'd1;
                state_q <= ST_MUL_GO;
              end
              J_P4: begin
                gy_q    <= sat48(pos_sum);
                k_q     <= K_W'(MOD_STEPS - 1);
                state_q <= ST_MOD;
              end
              J_VX, J_VY, J_W: state_q <= ST_DIV_GO;
              default: begin
                job_q   <= job_q + 4'd1;
                state_q <= ST_MUL_GO;
              end
            endcase
          end
        end
        ST_CORDIC: begin
          step_q <= step_q + 1'b1;
          if (step_q == STEP_W'(CORDIC_STEPS - 1)) begin
            job_q   <= J_P1;
            state_q <= ST_MUL_GO;
          end
        end
        ST_MOD: begin
          k_q <= k_q - 1'b1;
          if (k_q == '0) begin
            head_q <= head_fix[31:0];
            if (job_q_data.dt == '0) begin
              state_q <= ST_OUT;
            end else begin
              job_q   <= J_VX;
              state_q <= ST_MUL_GO;
            end
          end
        end
        ST_DIV_GO: state_q <= ST_DIV_WAIT;
        ST_DIV_WAIT: begin
          if (div_done) begin
            if (job_q == J_W) begin
              state_q <= ST_OUT;
            end else begin
              job_q   <= job_q + 4'd1;
              state_q <= ST_MUL_GO;
            end
          end
        end
        ST_OUT: begin
          if (out_free) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  fwo_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .sh_i    (mul_sh),
    .done_o  (mul_done),
    .res_o   (mul_res)
  );

  fwo_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .sat_o   (div_sat),
    .quo_o   (div_quo)
  );

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
